[rtl/ultrasonic_range_supervisor_core_defines.svh]
`ifndef ULTRASONIC_RANGE_SUPERVISOR_CORE_DEFINES_SVH
`define ULTRASONIC_RANGE_SUPERVISOR_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define URS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urs assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define URS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urs assertion failed");

`endif

[rtl/urs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package urs_pkg;

    localparam int ECHO_W   = 15;
    localparam int SPEED_W  = 16;
    localparam int DIST_W   = 10;
    localparam int COUNT_W  = 8;
    localparam int ADDR_W   = 2;
    localparam int DATA_W   = 16;
    localparam int PROD_W   = ECHO_W + SPEED_W;
    // Q0.16 product, then halved: drop 17 bits
    localparam int RAW_W    = PROD_W - 17;

    localparam logic [ECHO_W-1:0]  ECHO_TIMEOUT_US = ECHO_W'(30000);
    localparam logic [DIST_W-1:0]  DIST_SAT        = '1;
    localparam logic [COUNT_W-1:0] COUNT_SAT       = '1;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_SOUND_SPEED = 2'd0;
    localparam logic [ADDR_W-1:0] REG_MAX_DIST    = 2'd1;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD   = 2'd2;
    localparam logic [ADDR_W-1:0] REG_FAIL_LIMIT  = 2'd3;

    typedef struct packed {
        logic [SPEED_W-1:0] sound_speed_q16;
        logic [DIST_W-1:0]  max_distance_cm;
        logic [DIST_W-1:0]  change_threshold_cm;
        logic [COUNT_W-1:0] fail_limit;
    } cfg_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance_cm;
        logic               reading_valid;
        logic               space_free;
        logic               new_data;
        logic               sensor_disabled;
        logic [COUNT_W-1:0] fail_count;
    } res_t;

endpackage

`default_nettype wire

[rtl/urs_echo_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface urs_echo_if;
    import urs_pkg::*;

    logic              valid;
    logic              ready;
    logic [ECHO_W-1:0] echo_us;

    modport source (output valid, output echo_us, input ready);
    modport sink (input valid, input echo_us, output ready);
endinterface

`default_nettype wire

[rtl/urs_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface urs_result_if;
    import urs_pkg::*;

    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance_cm;
    logic               reading_valid;
    logic               space_free;
    logic               new_data;
    logic               sensor_disabled;
    logic [COUNT_W-1:0] fail_count;

    modport source (
        output valid, output distance_cm, output reading_valid, output space_free,
        output new_data, output sensor_disabled, output fail_count, input ready
    );
    modport sink (
        input valid, input distance_cm, input reading_valid, input space_free,
        input new_data, input sensor_disabled, input fail_count, output ready
    );
endinterface

`default_nettype wire

[rtl/urs_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface urs_cfg_if;
    import urs_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[rtl/urs_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module urs_cfg_regs (
    input  wire logic     clk,
    input  wire logic     rst_n,
    urs_cfg_if.sink       cfg,
    output urs_pkg::cfg_t cfg_q
);
    import urs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.addr)
                REG_SOUND_SPEED: cfg_next.sound_speed_q16     = cfg.data;
                REG_MAX_DIST:    cfg_next.max_distance_cm     = cfg.data[DIST_W-1:0];
                REG_THRESHOLD:   cfg_next.change_threshold_cm = cfg.data[DIST_W-1:0];
                REG_FAIL_LIMIT:  cfg_next.fail_limit          = cfg.data[COUNT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sound_speed_q16     <= SPEED_W'(2228);
            cfg_reg.max_distance_cm     <= DIST_W'(400);
            cfg_reg.change_threshold_cm <= DIST_W'(10);
            cfg_reg.fail_limit          <= COUNT_W'(5);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

`default_nettype wire

[rtl/urs_scale.sv]
`timescale 1ns / 1ps
`default_nettype none

module urs_scale (
    input  wire logic                      clk,
    input  wire logic                      load,
    input  wire logic [urs_pkg::ECHO_W-1:0]  echo_us,
    input  wire logic [urs_pkg::SPEED_W-1:0] sound_speed_q16,
    output logic      [urs_pkg::RAW_W-1:0]   raw_cm
);
    import urs_pkg::*;

    logic [ECHO_W-1:0] echo_clip;
    logic [PROD_W-1:0] prod;
    logic [RAW_W-1:0]  raw_reg;
    logic [RAW_W-1:0]  raw_next;

    // Echo past the timeout counts as no echo at all
    assign echo_clip = (echo_us > ECHO_TIMEOUT_US) ? '0 : echo_us;
    assign prod      = PROD_W'(echo_clip) * PROD_W'(sound_speed_q16);
    // Drop the Q0.16 fraction and halve for the round trip
    assign raw_next  = prod[PROD_W-1:17];
    assign raw_cm    = raw_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            raw_reg <= raw_next;
        end
    end
endmodule

`default_nettype wire

[rtl/urs_track.sv]
`timescale 1ns / 1ps
`default_nettype none

module urs_track (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    take,
    input  wire logic [urs_pkg::RAW_W-1:0] raw_cm,
    input  wire urs_pkg::cfg_t           cfg_q,
    output urs_pkg::res_t                res_q
);
    import urs_pkg::*;

    logic [COUNT_W-1:0] fail_reg,      fail_next;
    logic [DIST_W-1:0]  max_reg,       max_next;
    logic [DIST_W-1:0]  cur_reg,       cur_next;
    logic [DIST_W-1:0]  rep_reg,       rep_next;
    logic               free_reg,      free_next;
    logic               rep_free_reg,  rep_free_next;
    logic               disabled_reg,  disabled_next;
    res_t               res_reg,       res_next;

    logic               valid;
    logic [DIST_W-1:0]  sat_cm;
    logic [DIST_W-1:0]  max_upd;
    logic               free_upd;
    logic [DIST_W-1:0]  diff;
    logic               report;
    logic [COUNT_W-1:0] fail_inc;

    assign valid    = (raw_cm != '0) &&
                      ({{(RAW_W-DIST_W-1){1'b0}}, cfg_q.max_distance_cm, 1'b0} >= raw_cm);
    assign sat_cm   = (raw_cm > RAW_W'(DIST_SAT)) ? DIST_SAT : raw_cm[DIST_W-1:0];
    assign max_upd  = (sat_cm > max_reg) ? sat_cm : max_reg;
    assign free_upd = ({1'b0, sat_cm} + {1'b0, cfg_q.change_threshold_cm}) >
                      {1'b0, max_upd};
    assign diff     = (sat_cm >= rep_reg) ? (sat_cm - rep_reg) : (rep_reg - sat_cm);
    assign report   = (diff >= cfg_q.change_threshold_cm) || (free_upd != rep_free_reg);
    assign fail_inc = (fail_reg == COUNT_SAT) ? fail_reg : fail_reg + COUNT_W'(1);

    always_comb
    begin
        fail_next     = fail_reg;
        max_next      = max_reg;
        cur_next      = cur_reg;
        rep_next      = rep_reg;
        free_next     = free_reg;
        rep_free_next = rep_free_reg;
        disabled_next = disabled_reg;
        res_next      = res_reg;
        if (take)
        begin
            if (!disabled_reg && !valid)
            begin
                fail_next     = fail_inc;
                disabled_next = (fail_inc >= cfg_q.fail_limit);
            end
            else if (!disabled_reg)
            begin
                fail_next = '0;
                cur_next  = sat_cm;
                max_next  = max_upd;
                free_next = free_upd;
                if (report)
                begin
                    rep_next      = sat_cm;
                    rep_free_next = free_upd;
                end
            end
            res_next.distance_cm     = cur_next;
            res_next.reading_valid   = !disabled_reg && valid;
            res_next.space_free      = free_next;
            res_next.new_data        = !disabled_reg && valid && report;
            res_next.sensor_disabled = disabled_next;
            res_next.fail_count      = fail_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_reg     <= '0;
            max_reg      <= '0;
            cur_reg      <= '0;
            rep_reg      <= '0;
            free_reg     <= 1'b0;
            rep_free_reg <= 1'b0;
            disabled_reg <= 1'b0;
        end
        else
        begin
            fail_reg     <= fail_next;
            max_reg      <= max_next;
            cur_reg      <= cur_next;
            rep_reg      <= rep_next;
            free_reg     <= free_next;
            rep_free_reg <= rep_free_next;
            disabled_reg <= disabled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_q = res_reg;

`include "ultrasonic_range_supervisor_core_defines.svh"

    `URS_ASSERT_NEXT(a_disable_sticks, clk, rst_n, disabled_reg, disabled_reg)
    `URS_ASSERT_NEXT(a_max_tracks_cur, clk, rst_n, 1'b1, max_reg >= cur_reg)
    `URS_ASSERT_NEXT(a_frozen_when_off, clk, rst_n, disabled_reg, $stable(cur_reg) && $stable(fail_reg))
endmodule

`default_nettype wire

[rtl/ultrasonic_range_supervisor_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Ultrasonic range supervisor. Each item on the sample channel is one echo
// pulse length in microseconds (anything above 30000 counts as a timeout);
// the block scales it by the programmed Q0.16 sound speed, halves it to get a
// one-way distance in centimetres, and checks it against zero and twice the
// nominal range. Each sample item yields exactly one result item carrying the
// held distance, the validity of this reading, the free-space decision, the
// new-data flag, the disabled flag and the consecutive-failure count. Once the
// failure count reaches fail_limit the sensor stays disabled until reset.
// Throughput is one item per clock while the result side is ready; a result
// goes valid once its sample has passed three registers: the input register,
// the product register behind the single 15x16 multiplier, and the result
// register behind the state update. The state update is a single registered
// step, so items may follow back to back.
// A full result register stalls the pipe; the sample channel keeps taking
// items until every stage holds one. Configuration writes are taken every
// cycle and must only be issued while no item is in flight.

module ultrasonic_range_supervisor_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    urs_echo_if.sink      sample,
    urs_result_if.source  result,
    urs_cfg_if.sink       cfg
);
    import urs_pkg::*;

    cfg_t              cfg_q;
    res_t              res_q;

    logic              in_v_reg,   in_v_next;
    logic [ECHO_W-1:0] echo_reg;
    logic              raw_v_reg,  raw_v_next;
    logic              out_v_reg,  out_v_next;

    logic              adv_out;    // raw stage moves into result register
    logic              adv_raw;    // input stage moves into raw stage
    logic              take_in;    // sample item accepted
    logic [RAW_W-1:0]  raw_cm;

    // Advance each stage when the one after it is empty or also moving
    assign adv_out      = raw_v_reg && (!out_v_reg || result.ready);
    assign adv_raw      = in_v_reg && (!raw_v_reg || adv_out);
    assign sample.ready = !in_v_reg || adv_raw;
    assign take_in      = sample.valid && sample.ready;

    always_comb
    begin
        in_v_next  = take_in  || (in_v_reg  && !adv_raw);
        raw_v_next = adv_raw  || (raw_v_reg && !adv_out);
        out_v_next = adv_out  || (out_v_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            raw_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg  <= in_v_next;
            raw_v_reg <= raw_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Hold the echo until the multiplier stage takes it
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            echo_reg <= sample.echo_us;
        end
    end

    urs_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    urs_scale u_scale (
        .clk             (clk),
        .load            (adv_raw),
        .echo_us         (echo_reg),
        .sound_speed_q16 (cfg_q.sound_speed_q16),
        .raw_cm          (raw_cm)
    );

    urs_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (adv_out),
        .raw_cm (raw_cm),
        .cfg_q  (cfg_q),
        .res_q  (res_q)
    );

    // Drive the result channel straight from the result register
    assign result.valid           = out_v_reg;
    assign result.distance_cm     = res_q.distance_cm;
    assign result.reading_valid   = res_q.reading_valid;
    assign result.space_free      = res_q.space_free;
    assign result.new_data        = res_q.new_data;
    assign result.sensor_disabled = res_q.sensor_disabled;
    assign result.fail_count      = res_q.fail_count;

`include "ultrasonic_range_supervisor_core_defines.svh"

    `URS_ASSERT_NOW(a_valid_clears_fail, clk, rst_n, out_v_reg && res_q.reading_valid, res_q.fail_count == '0)
    `URS_ASSERT_NOW(a_report_needs_valid, clk, rst_n, out_v_reg && res_q.new_data, res_q.reading_valid)
    `URS_ASSERT_NOW(a_off_means_invalid, clk, rst_n, out_v_reg && res_q.sensor_disabled, !res_q.reading_valid)
endmodule

`default_nettype wire

[bench/urs_reading_checker.sv]
`timescale 1ns / 1ps

// Watches the sample, result and configuration channels. Each accepted echo
// item is turned into the expected result item, and each accepted result
// item is compared with the oldest one still waiting.
module urs_reading_checker
    import urs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    urs_echo_if   sample,
    urs_result_if result,
    urs_cfg_if    cfg,
    output int    mismatches,
    output int    outstanding,
    output int    checked,
    output int    reports,
    output logic  off_seen
);

    localparam cfg_t SETTINGS_AT_RESET = '{
        sound_speed_q16:     16'd2228,
        max_distance_cm:     10'd400,
        change_threshold_cm: 10'd10,
        fail_limit:          8'd5
    };

    cfg_t               settings;
    logic [COUNT_W-1:0] fail_run;
    logic [DIST_W-1:0]  peak_cm;
    logic [DIST_W-1:0]  held_cm;
    logic [DIST_W-1:0]  last_report_cm;
    logic               free_state;
    logic               last_report_free;
    logic               sensor_off;

    res_t expected_readings [$];
    int   err_n;
    int   checked_n;
    int   reports_n;
    logic off_n;

    function automatic res_t predict_reading(input logic [ECHO_W-1:0] echo);
        logic [ECHO_W-1:0] pulse;
        logic [PROD_W-1:0] product;
        logic [RAW_W-1:0]  raw;
        logic [DIST_W:0]   margin;
        logic [DIST_W-1:0] gap;
        logic              ok;
        logic              report;
        res_t              r;
        ok = 1'b0;
        report = 1'b0;
        if (!sensor_off) begin
            // an echo past the timeout reads as no echo at all
            pulse = (echo > ECHO_TIMEOUT_US) ? '0 : echo;
            product = PROD_W'(pulse) * PROD_W'(settings.sound_speed_q16);
            // drop the Q0.16 fraction and halve for the one-way distance
            raw = product[PROD_W-1:17];
            ok = (raw != '0) && (raw <= {settings.max_distance_cm, 1'b0});
            if (!ok) begin
                if (fail_run != COUNT_SAT)
                    fail_run = fail_run + 1'b1;
                if (fail_run >= settings.fail_limit)
                    sensor_off = 1'b1;
            end else begin
                fail_run = '0;
                held_cm = (raw > DIST_SAT) ? DIST_SAT : raw[DIST_W-1:0];
                if (held_cm > peak_cm)
                    peak_cm = held_cm;
                margin = {1'b0, held_cm} + {1'b0, settings.change_threshold_cm};
                free_state = margin > {1'b0, peak_cm};
                gap = (held_cm >= last_report_cm) ? held_cm - last_report_cm
                                                  : last_report_cm - held_cm;
                if (gap >= settings.change_threshold_cm || free_state != last_report_free) begin
                    last_report_cm = held_cm;
                    last_report_free = free_state;
                    report = 1'b1;
                end
            end
        end
        r.distance_cm     = held_cm;
        r.reading_valid   = ok;
        r.space_free      = free_state;
        r.new_data        = report;
        r.sensor_disabled = sensor_off;
        r.fail_count      = fail_run;
        return r;
    endfunction

    task automatic compare_field(input string label, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want_v, got_v);
            err_n++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            settings         = SETTINGS_AT_RESET;
            fail_run         = '0;
            peak_cm          = '0;
            held_cm          = '0;
            last_report_cm   = '0;
            free_state       = 1'b0;
            last_report_free = 1'b0;
            sensor_off       = 1'b0;
            expected_readings.delete();
            err_n     = 0;
            checked_n = 0;
            reports_n = 0;
            off_n     = 1'b0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.addr)
                    REG_SOUND_SPEED: settings.sound_speed_q16 = cfg.data[SPEED_W-1:0];
                    REG_MAX_DIST:    settings.max_distance_cm = cfg.data[DIST_W-1:0];
                    REG_THRESHOLD:   settings.change_threshold_cm = cfg.data[DIST_W-1:0];
                    REG_FAIL_LIMIT:  settings.fail_limit = cfg.data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
                expected_readings.push_back(predict_reading(sample.echo_us));
            if (result.valid && result.ready) begin
                if (expected_readings.size() == 0) begin
                    $display("%0t: result item with no reading pending, distance %0d",
                             $time, result.distance_cm);
                    err_n++;
                end else begin
                    want = expected_readings.pop_front();
                    compare_field("distance_cm", want.distance_cm, result.distance_cm);
                    compare_field("reading_valid", want.reading_valid, result.reading_valid);
                    compare_field("space_free", want.space_free, result.space_free);
                    compare_field("new_data", want.new_data, result.new_data);
                    compare_field("sensor_disabled", want.sensor_disabled,
                                  result.sensor_disabled);
                    compare_field("fail_count", want.fail_count, result.fail_count);
                    checked_n++;
                    if (want.new_data)
                        reports_n++;
                    if (want.sensor_disabled)
                        off_n = 1'b1;
                end
            end
        end
        mismatches  <= err_n;
        outstanding <= expected_readings.size();
        checked     <= checked_n;
        reports     <= reports_n;
        off_seen    <= off_n;
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

// Top of the bench: makes the clock and reset, drives echo items and register
// writes, paces the result side, and gives the verdict. All checking lives in
// the checker instance beside the block.
module testbench;
    import urs_pkg::*;

    // longest stretch with no item moved on any channel before giving up
    localparam int QUIET_LIMIT = 4000;
    // the one long hold-off on the result side, long enough to fill the pipe
    localparam int HOLD_CYCLES = 300;
    // drain time at the end: time for the three stages to empty, with margin
    localparam int TAIL_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    int   src_idle_pct;
    int   snk_stall_pct;
    logic hold_request;
    logic hold_served;
    int   sent;
    int   quiet;

    int   mismatches;
    int   outstanding;
    int   checked;
    int   reports;
    logic off_seen;

    urs_echo_if   sample ();
    urs_result_if result ();
    urs_cfg_if    cfg ();

    always #1 clk = ~clk;

    ultrasonic_range_supervisor_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample),
        .result (result),
        .cfg    (cfg)
    );

    urs_reading_checker reading_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .result      (result),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked),
        .reports     (reports),
        .off_seen    (off_seen)
    );

    // Offer one echo item, idling first at the current rate. Valid is only
    // lowered inside the idle loop, so back-to-back items keep it high and it
    // never sees two assignments in one step.
    task automatic send_echo(input logic [ECHO_W-1:0] echo);
        while ($urandom_range(99) < src_idle_pct) begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid   <= 1'b1;
        sample.echo_us <= echo;
        do @(posedge clk); while (!sample.ready);
        sent++;
    endtask

    // Drop valid, then hold until every expected result item has come back.
    // The first edge lets the checker count the item taken at this edge.
    task automatic settle();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write all four registers back to back, valid held high across them.
    // Unused upper data bits carry noise, which the block must mask off.
    task automatic program_settings(input logic [SPEED_W-1:0] speed,
                                    input logic [DIST_W-1:0]  span,
                                    input logic [DIST_W-1:0]  step_cm,
                                    input logic [COUNT_W-1:0] limit);
        logic [ADDR_W-1:0] idx  [4];
        logic [DATA_W-1:0] word [4];
        idx = '{REG_SOUND_SPEED, REG_MAX_DIST, REG_THRESHOLD, REG_FAIL_LIMIT};
        word[0] = speed;
        word[1] = {6'($urandom), span};
        word[2] = {6'($urandom), step_cm};
        word[3] = {8'($urandom), limit};
        for (int k = 0; k < 4; k++) begin
            cfg.valid <= 1'b1;
            cfg.addr  <= idx[k];
            cfg.data  <= word[k];
            do @(posedge clk); while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic set_idle(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct <= snk_pct;
    endtask

    // Most echoes walk around the previous good one so that distance moves
    // near the change threshold; the rest are timeouts, zero, over-range and
    // fully random noise. A clean walk never leaves the valid echo band.
    function automatic logic [ECHO_W-1:0] pick_echo(input int prev, input int step,
                                                    input int floor_us, input bit clean);
        int roll;
        int v;
        roll = clean ? 0 : int'($urandom_range(99));
        if (roll < 70) begin
            v = prev + int'($urandom_range(2 * step)) - step;
            if (v < floor_us)
                v = floor_us;
            if (v > int'(ECHO_TIMEOUT_US))
                v = int'(ECHO_TIMEOUT_US);
        end else if (roll < 78) begin
            v = int'($urandom_range(32767));
        end else if (roll < 83) begin
            v = 0;
        end else if (roll < 88) begin
            v = int'($urandom_range(32767, int'(ECHO_TIMEOUT_US) + 1));
        end else begin
            v = int'($urandom_range(int'(ECHO_TIMEOUT_US), 1));
        end
        return ECHO_W'(v);
    endfunction

    task automatic run_random(input int count, input int step, input int floor_us,
                              input bit clean);
        int prev;
        logic [ECHO_W-1:0] echo;
        prev = int'($urandom_range(int'(ECHO_TIMEOUT_US), floor_us));
        repeat (count) begin
            echo = pick_echo(prev, step, floor_us, clean);
            send_echo(echo);
            if (echo >= floor_us && echo <= ECHO_TIMEOUT_US)
                prev = echo;
        end
    endtask

    // Result side: random stalls at the current rate, plus one long hold-off
    // when asked, counted here while the sender keeps offering items.
    initial begin
        result.ready = 1'b0;
        hold_served  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request && !hold_served) begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served = 1'b1;
            end else begin
                result.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which no channel moves an item.
    always @(posedge clk) begin
        if (!rst_n || (sample.valid && sample.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("Timeout: nothing moved for %0d cycles, %0d results pending",
                     quiet, outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [ECHO_W-1:0] burst [$];
        sample.valid   = 1'b0;
        sample.echo_us = '0;
        cfg.valid      = 1'b0;
        cfg.addr       = '0;
        cfg.data       = '0;
        rst_n          = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_request   = 1'b0;
        sent           = 0;
        quiet          = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, fail limit five: timeouts, echoes past the timeout,
        // an echo too short to give a centimetre, repeated and small moves,
        // and a run of four misses that a good reading then clears.
        burst = '{15'd0, 15'd30001, 15'd32767, 15'd1000, 15'd1000, 15'd1590,
                  15'd2180, 15'd600, 15'd30000, 15'd1, 15'd59, 15'd0, 15'd0,
                  15'd0, 15'd0, 15'd5000, 15'd16384, 15'd300};
        foreach (burst[i])
            send_echo(burst[i]);
        settle();

        // Full-scale speed and range, zero threshold: distances beyond the
        // result width saturate, the edge of twice the range, and a zero
        // threshold that reports every good reading.
        program_settings(16'hFFFF, 10'd1023, 10'd0, 8'd255);
        burst = '{15'd30000, 15'd4092, 15'd4094, 15'd4096, 15'd2, 15'd3, 15'd32767};
        foreach (burst[i])
            send_echo(burst[i]);
        settle();

        // Nominal settings, no idling, with the long result hold-off that
        // fills the pipe and stalls the sample channel.
        set_idle(0, 0);
        program_settings(16'd2228, 10'd400, 10'd10, 8'd255);
        hold_request <= 1'b1;
        run_random(120, 600, 59, 1'b0);
        settle();

        // Random speed and range, sender mostly idle.
        set_idle(79, 0);
        program_settings(16'($urandom_range(65535, 1000)), 10'($urandom_range(1023, 100)),
                         10'($urandom_range(50)), 8'd200);
        run_random(100, 800, 1, 1'b0);
        settle();

        // Zero speed and range, widest threshold: every reading misses.
        set_idle(0, 79);
        program_settings(16'd0, 10'd0, 10'd1023, 8'd255);
        run_random(30, 2000, 1, 1'b0);
        settle();

        // Full-scale speed, receiver mostly stalling: saturated distances.
        set_idle(0, 79);
        program_settings(16'hFFFF, 10'd1023, 10'($urandom_range(1023)), 8'd255);
        run_random(100, 300, 1, 1'b0);
        settle();

        // Fail limit one with only good readings, so the sensor stays on.
        set_idle(16, 16);
        program_settings(16'd2228, 10'd1023, 10'($urandom_range(40, 1)), 8'd1);
        run_random(80, 700, 59, 1'b1);
        settle();

        // Everything random.
        set_idle(16, 16);
        program_settings(16'($urandom), 10'($urandom), 10'($urandom_range(100)), 8'd255);
        run_random(120, 1000, 1, 1'b0);
        settle();

        // Fail limit zero: the first miss locks the sensor out, and every
        // later item must be ignored with the held state shown.
        set_idle(0, 0);
        program_settings(16'd2228, 10'd300, 10'd5, 8'd0);
        burst = '{15'd3000, 15'd3100, 15'd0};
        foreach (burst[i])
            send_echo(burst[i]);
        repeat (10)
            send_echo(ECHO_W'($urandom));
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d echo items under nine register settings; %0d results compared,",
                 sent, checked);
        $display("%0d change reports, sensor lockout %0s.", reports,
                 off_seen ? "reached" : "not reached");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
